FILE: hw/rtl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  // fixed port widths
  localparam int PAGE_W    = 16;
  localparam int CFG_W     = 4;
  localparam int IDX_OUT_W = 3;
  localparam int FAULT_W   = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

  // frame index and recency rank width
  function automatic int idx_width(input int max_frames);
    return (max_frames > 1) ? $clog2(max_frames) : 1;
  endfunction

  // width of a count 0..max_frames
  function automatic int cnt_width(input int max_frames);
    return $clog2(max_frames + 1);
  endfunction

  // search record: vld, page, cnt, found, hit_idx, hit_rank, empty, empty_idx,
  // best_rank, best_idx, best_page
  function automatic int rec_width(input int max_frames, input int page_bits);
    return 3 + 2 * page_bits + cnt_width(max_frames) + 5 * idx_width(max_frames);
  endfunction

  // update broadcast: en, idx, miss, page, was_valid, old_rank
  function automatic int upd_width(input int max_frames, input int page_bits);
    return 3 + page_bits + 2 * idx_width(max_frames);
  endfunction

endpackage

FILE: hw/rtl/lru_cell.sv
`timescale 1ns / 1ps

module lru_cell import lru_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int IDX        = 0,
  localparam int REC_W     = rec_width(MAX_FRAMES, PAGE_BITS),
  localparam int UPD_W     = upd_width(MAX_FRAMES, PAGE_BITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [REC_W-1:0] rec_i,
  output logic [REC_W-1:0] rec_o,
  input  logic [UPD_W-1:0] upd_i
);

  localparam int IW = idx_width(MAX_FRAMES);
  localparam int CW = cnt_width(MAX_FRAMES);
  localparam int PB = PAGE_BITS;

  typedef struct packed {
    logic          vld;
    logic [PB-1:0] page;
    logic [CW-1:0] cnt;
    logic          found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic          empty;
    logic [IW-1:0] empty_idx;
    logic [IW-1:0] best_rank;
    logic [IW-1:0] best_idx;
    logic [PB-1:0] best_page;
  } rec_t;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic          miss;
    logic [PB-1:0] page;
    logic          was_valid;
    logic [IW-1:0] old_rank;
  } upd_t;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  rec_t          rin;
  rec_t          rout;
  rec_t          rec_r;
  upd_t          upd;
  logic [PB-1:0] page_r;
  logic          valid_r;
  logic [IW-1:0] rank_r;
  logic          active;

  assign rin    = rec_i;
  assign upd    = upd_i;
  assign rec_o  = rec_r;
  assign active = MY_POS < rin.cnt;

  always_comb begin
    rout = rin;
    if (rin.vld && active) begin
      if (!rin.found && valid_r && (page_r == rin.page)) begin
        rout.found    = 1'b1;
        rout.hit_idx  = MY_IDX;
        rout.hit_rank = rank_r;
      end
      if (!rin.empty && !valid_r) begin
        rout.empty     = 1'b1;
        rout.empty_idx = MY_IDX;
      end
      // >= so the highest index wins a tie, as the victim scan does
      if (rank_r >= rin.best_rank) begin
        rout.best_rank = rank_r;
        rout.best_idx  = MY_IDX;
        rout.best_page = page_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (adv) begin
      rec_r <= rout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd.en) begin
      if (upd.idx == MY_IDX) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (!upd.was_valid || (rank_r < upd.old_rank))) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.miss && (upd.idx == MY_IDX)) begin
      page_r <= upd.page;
    end
  end

endmodule

FILE: hw/rtl/lru_page_replacement_core.sv
`timescale 1ns / 1ps

// LRU page replacement over MAX_FRAMES fully associative frames. Each frame
// is a cell holding its page, valid bit and recency rank (0 = most recent).
// An accepted page reference becomes a search record that walks the row of
// cells one cell per cycle (the whole row holds while a finished record
// waits on a full, stalled output register), collecting the first hit, the
// first empty frame and the least recent frame among the active ones; as it
// leaves the last cell the chosen frame is updated in every cell at once and
// the result lands in the output register. The next reference is taken as
// soon as the previous one has been written, even if its result is still
// waiting on out_stall.
// frames_in_use is sampled when a reference is accepted: 0 acts as 1 and
// values above MAX_FRAMES act as MAX_FRAMES. fault_count saturates.
module lru_page_replacement_core import lru_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_W-1:0]    in_page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [IDX_OUT_W-1:0] out_frame_index,
  output logic                 out_evicted_valid,
  output logic [PAGE_W-1:0]    out_evicted_page,
  output logic [FAULT_W-1:0]   out_fault_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_frames_in_use
);

  localparam int IW    = idx_width(MAX_FRAMES);
  localparam int CW    = cnt_width(MAX_FRAMES);
  localparam int PB    = PAGE_BITS;
  localparam int REC_W = rec_width(MAX_FRAMES, PAGE_BITS);

  typedef struct packed {
    logic          vld;
    logic [PB-1:0] page;
    logic [CW-1:0] cnt;
    logic          found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic          empty;
    logic [IW-1:0] empty_idx;
    logic [IW-1:0] best_rank;
    logic [IW-1:0] best_idx;
    logic [PB-1:0] best_page;
  } rec_t;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic          miss;
    logic [PB-1:0] page;
    logic          was_valid;
    logic [IW-1:0] old_rank;
  } upd_t;

  logic [CFG_W-1:0]   frames_r;
  logic [CW-1:0]      act_cnt;
  logic               busy_r;
  logic               in_acc;
  logic               adv;
  logic               apply;
  rec_t               entry_r;
  rec_t               entry_nxt;
  rec_t               last;
  upd_t               upd;
  logic [REC_W-1:0]   link [MAX_FRAMES+1];
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic               evict;
  logic [IW-1:0]      frame_sel;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic                 out_ev_valid_r;
  logic [PAGE_W-1:0]    out_ev_page_r;
  logic [FAULT_W-1:0]   out_fault_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  always_comb begin
    if (frames_r == '0) begin
      act_cnt = CW'(1);
    end else if (int'(frames_r) > MAX_FRAMES) begin
      act_cnt = CW'(MAX_FRAMES);
    end else begin
      act_cnt = CW'(frames_r);
    end
  end

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;

  always_comb begin
    entry_nxt      = '0;
    entry_nxt.vld  = 1'b1;
    entry_nxt.page = PB'(in_page);
    entry_nxt.cnt  = act_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (in_acc) begin
      entry_r <= entry_nxt;
    end else if (adv) begin
      entry_r.vld <= 1'b0;
    end
  end

  assign link[0] = entry_r;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    lru_cell #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (k)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .rec_i(link[k]),
      .rec_o(link[k+1]),
      .upd_i(upd)
    );
  end

  assign last = link[MAX_FRAMES];

  // the record parks in the last cell while the output register is full and stalled
  assign adv   = !(last.vld && out_valid_r && out_stall);
  assign apply = last.vld && adv;
  assign evict = !last.found && !last.empty;

  always_comb begin
    priority if (last.found) begin
      frame_sel = last.hit_idx;
    end else if (last.empty) begin
      frame_sel = last.empty_idx;
    end else begin
      frame_sel = last.best_idx;
    end
  end

  always_comb begin
    upd.en        = apply;
    upd.idx       = frame_sel;
    upd.miss      = !last.found;
    upd.page      = last.page;
    upd.was_valid = last.found || !last.empty;
    upd.old_rank  = last.found ? last.hit_rank : last.best_rank;
  end

  always_comb begin
    fault_nxt = fault_r;
    if (!last.found && (fault_r != '1)) begin
      fault_nxt = fault_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (apply) begin
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (apply) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_hit_r      <= last.found;
      out_idx_r      <= IDX_OUT_W'(frame_sel);
      out_ev_valid_r <= evict;
      out_ev_page_r  <= evict ? PAGE_W'(last.best_page) : '0;
      out_fault_r    <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_idx_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_fault_r;

`ifndef SYNTHESIS
  logic [MAX_FRAMES:0] chain_vld;

  always_comb begin
    for (int k = 0; k <= MAX_FRAMES; k++) begin
      chain_vld[k] = link[k][REC_W-1];
    end
  end

  // at most one reference in flight along the chain
  a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one search record in the cell chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (chain_vld == '0))
    else $error("search record present while not busy");

  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fault_r >= $past(fault_r)))
    else $error("fault count went backwards");

  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> !busy_r)
    else $error("result posted while reference still in progress");
`endif

endmodule

FILE: test/lru_replace_checker.sv
`timescale 1ns / 1ps

module lru_replace_checker import lru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PAGE_W-1:0]    in_page,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_hit,
  input  logic [IDX_OUT_W-1:0] out_frame_index,
  input  logic                 out_evicted_valid,
  input  logic [PAGE_W-1:0]    out_evicted_page,
  input  logic [FAULT_W-1:0]   out_fault_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_frames_in_use,
  output int                   fails,
  output int                   pending
);

  localparam int NFRAMES = MAX_FRAMES_DEF;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame;
    logic                 ev_valid;
    logic [PAGE_W-1:0]    ev_page;
    logic [FAULT_W-1:0]   faults;
  } access_t;

  logic [PAGE_W-1:0]  fr_page  [NFRAMES];
  logic               fr_valid [NFRAMES];
  logic [2:0]         fr_rank  [NFRAMES];
  logic [FAULT_W-1:0] fault_total;
  logic [CFG_W-1:0]   frames_cfg;
  access_t            lookups_due[$];
  access_t            want;

  // Model one reference against the frame table, updating it in place.
  function automatic access_t next_access(input logic [PAGE_W-1:0] pg);
    access_t    r;
    int         n;
    int         f;
    bit         found;
    bit         spare;
    bit         was_valid;
    logic [2:0] best;
    logic [2:0] old_rank;
    r = '0;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg);
    found = 0;
    spare = 0;
    f = 0;
    for (int i = 0; i < n; i++)
      if (!found && fr_valid[i] && fr_page[i] == pg) begin
        f = i;
        found = 1;
      end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      for (int i = 0; i < n; i++)
        if (!spare && !fr_valid[i]) begin
          f = i;
          spare = 1;
        end
      if (!spare) begin
        // ties go to the highest index
        best = '0;
        f = 0;
        for (int i = 0; i < n; i++)
          if (fr_rank[i] >= best) begin
            best = fr_rank[i];
            f = i;
          end
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[f];
      end
      fr_page[f] = pg;
      if (fault_total != '1) fault_total = fault_total + 1'b1;
    end
    // inactive frames age too, so the order stays total
    was_valid = fr_valid[f];
    old_rank  = fr_rank[f];
    for (int i = 0; i < NFRAMES; i++)
      if (i != f && fr_valid[i] && (!was_valid || fr_rank[i] < old_rank))
        fr_rank[i] = fr_rank[i] + 1'b1;
    fr_rank[f]  = '0;
    fr_valid[f] = 1'b1;
    r.frame  = f[IDX_OUT_W-1:0];
    r.faults = fault_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fails   = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFRAMES; i++) begin
        fr_page[i]  = '0;
        fr_valid[i] = 1'b0;
        fr_rank[i]  = '0;
      end
      fault_total = '0;
      frames_cfg  = FRAMES_RESET;
      lookups_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) frames_cfg = cfg_frames_in_use;
      if (out_valid && !out_stall) begin
        if (lookups_due.size() == 0) begin
          fails++;
          $display("%0t: result beat with none expected, actual hit=%0b frame=%0d",
                   $time, out_hit, out_frame_index);
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("frame_index", 32'(want.frame), 32'(out_frame_index));
          check_field("evicted_valid", 32'(want.ev_valid), 32'(out_evicted_valid));
          check_field("evicted_page", 32'(want.ev_page), 32'(out_evicted_page));
          check_field("fault_count", want.faults, out_fault_count);
        end
      end
      if (in_valid && !in_stall) lookups_due.push_back(next_access(in_page));
    end
    pending = lookups_due.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lru_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYC  = 12;
  localparam int PHASES      = 13;
  localparam int PER_PHASE   = 50;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_W-1:0]    in_page;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [IDX_OUT_W-1:0] out_frame_index;
  logic                 out_evicted_valid;
  logic [PAGE_W-1:0]    out_evicted_page;
  logic [FAULT_W-1:0]   out_fault_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_frames_in_use;

  int                fails;
  int                pending;
  int                quiet_cycles;
  bit                gaps_on;
  logic [PAGE_W-1:0] pool [16];
  logic [PAGE_W-1:0] pg;
  logic [CFG_W-1:0]  fsel;
  int                window;
  int                pick;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_page_replacement_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use)
  );

  lru_replace_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .fails             (fails),
    .pending           (pending)
  );

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lru_page_replacement_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result-side back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_page(input logic [PAGE_W-1:0] p);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_page  = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    cfg_valid         = 1'b1;
    cfg_frames_in_use = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop valid, let every lookup come back, then let the pipe empty
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_page           = '0;
    cfg_valid         = 1'b0;
    cfg_frames_in_use = '0;
    gaps_on           = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // fill all eight frames, one hit, then an eviction of the oldest
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0004);
    send_page(16'hFFFF);
    send_page(16'h1234);
    settle();

    // zero frames acts as one; page in an inactive frame misses and
    // lands in frame 0, leaving a duplicate resident
    write_frames(4'd0);
    send_page(16'h5555);
    send_page(16'h5555);
    settle();

    // oversized count acts as eight; duplicate resolves to lowest index
    write_frames(4'd15);
    send_page(16'h5555);
    send_page(16'h8000);
    send_page(16'h7FFF);
    settle();

    write_frames(4'd3);
    send_page(16'h0002);
    send_page(16'h9999);
    send_page(16'hABCD);
    send_page(16'h0002);
    settle();

    for (int i = 0; i < 16; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       fsel = 4'd1;
        1:       fsel = 4'd8;
        2:       fsel = 4'd0;
        3:       fsel = 4'd15;
        default: fsel = CFG_W'($urandom_range(0, 15));
      endcase
      write_frames(fsel);
      if (ph >= PHASES - 2) gaps_on = 1'b0;
      window = $urandom_range(1, 16);
      pool[4'($urandom_range(0, 15))] = PAGE_W'($urandom_range(0, 65535));
      for (int k = 0; k < PER_PHASE; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)      pg = pool[4'($urandom_range(0, window - 1))];
        else if (pick < 8) pg = PAGE_W'($urandom_range(0, 15));
        else               pg = PAGE_W'($urandom_range(0, 65535));
        send_page(pg);
      end
      settle();
    end

    if (fails == 0) begin
      $display("lru_page_replacement_core: match");
    end else begin
      $display("lru_page_replacement_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lru_pkg.sv
hw/rtl/lru_cell.sv
hw/rtl/lru_page_replacement_core.sv
test/lru_replace_checker.sv
test/tb_top.sv
